/* sv/s2a_pkg.sv */
`timescale 1ns / 1ps
// Package for the signed integer to ASCII radix unit.
// Holds the item class type, ASCII constants and the digit encoder; no dependencies.
package s2a_pkg;

	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;
	localparam logic [5:0] DIGIT_TEN = 6'd10;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_UPPER = 7'h41;
	localparam logic [6:0] CH_LOWER = 7'h61;
	localparam logic [6:0] CH_MINUS = 7'h2D;

	typedef struct packed {
		logic       neg;
		logic       upper;
		logic [5:0] radix;
	} item_cls_t;

	function automatic logic [6:0] digit_ascii(input logic [5:0] d, input logic up);
		logic [6:0] base;
		begin
			base = up ? CH_UPPER : CH_LOWER;
			if (d >= DIGIT_TEN) begin
				digit_ascii = {1'b0, d - DIGIT_TEN} + base;
			end else begin
				digit_ascii = {1'b0, d} + CH_ZERO;
			end
		end
	endfunction

endpackage

/* sv/s2a_front.sv */
`timescale 1ns / 1ps
// Front end: takes requests, clamps the radix, splits sign and magnitude.
// Depends on s2a_pkg.
module s2a_front import s2a_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         start,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic        [5:0]            radix,
	input  logic                         upper_case,
	input  logic                         q_full,
	output logic                         busy,
	output logic                         push,
	output item_cls_t                    cls,
	output logic        [VALUE_BITS-1:0] mag
);

	logic [VALUE_BITS-1:0] raw;

	assign raw  = value;
	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		cls.neg   = raw[VALUE_BITS-1];
		cls.upper = upper_case;
		if (radix < RADIX_MIN) begin
			cls.radix = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			cls.radix = RADIX_MAX;
		end else begin
			cls.radix = radix;
		end
		mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	end

endmodule

/* sv/s2a_queue.sv */
`timescale 1ns / 1ps
// Two-entry request queue between front and back end.
// Depends on nothing.
module s2a_queue #(
	parameter int W = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] data_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* sv/s2a_back.sv */
`timescale 1ns / 1ps
// Back end: repeated division by the radix, four quotient bits per cycle,
// digit buffer, and emission most significant digit first. Depends on s2a_pkg.
module s2a_back import s2a_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  item_cls_t             q_cls,
	input  logic [VALUE_BITS-1:0] q_mag,
	output logic                  pop,
	output logic [6:0]            character,
	output logic                  last,
	output logic                  strobe
);

	localparam int STEPS = (VALUE_BITS + 3) / 4;
	localparam int DW    = STEPS * 4;
	localparam int SW    = $clog2(STEPS);
	localparam int AW    = $clog2(VALUE_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]    state_q;
	logic [DW-1:0] work_q;
	logic [5:0]    rem_q;
	logic [5:0]    rad_q;
	logic          neg_q;
	logic          upper_q;
	logic [SW-1:0] step_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] rd_idx_q;

	logic [5:0]    digit_mem [VALUE_BITS];
	logic [5:0]    mem_rd_q;

	logic          emit_s1;
	logic          sign_s1;
	logic          last_s1;
	logic          upper_s1;
	logic [6:0]    character_q;
	logic          last_q;
	logic          strobe_q;

	logic [6:0]    r_nx;
	logic [DW-1:0] w_nx;
	logic          step_last;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign step_last = (step_q == SW'(STEPS - 1));
	assign character = character_q;
	assign last      = last_q;
	assign strobe    = strobe_q;

	always_comb begin
		r_nx = {1'b0, rem_q};
		w_nx = work_q;
		for (int i = 0; i < 4; i++) begin
			r_nx = {r_nx[5:0], w_nx[DW-1]};
			w_nx = {w_nx[DW-2:0], 1'b0};
			if (r_nx >= {1'b0, rad_q}) begin
				r_nx    = r_nx - {1'b0, rad_q};
				w_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			emit_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			emit_s1  <= 1'b0;
			strobe_q <= emit_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						step_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_last) begin
						step_q <= '0;
						if (w_nx == '0) begin
							rd_idx_q <= cnt_q;
							state_q  <= neg_q ? ST_SIGN : ST_EMIT;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SIGN: begin
					emit_s1 <= 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					emit_s1 <= 1'b1;
					if (rd_idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		sign_s1  <= (state_q == ST_SIGN);
		last_s1  <= (state_q == ST_EMIT) && (rd_idx_q == '0);
		upper_s1 <= upper_q;
		if (pop) begin
			work_q  <= DW'(q_mag);
			rem_q   <= '0;
			rad_q   <= q_cls.radix;
			neg_q   <= q_cls.neg;
			upper_q <= q_cls.upper;
		end else if (state_q == ST_DIV) begin
			work_q <= w_nx;
			rem_q  <= step_last ? 6'd0 : r_nx[5:0];
		end
		if (emit_s1) begin
			character_q <= sign_s1 ? CH_MINUS : digit_ascii(mem_rd_q, upper_s1);
			last_q      <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && step_last) begin
			digit_mem[cnt_q] <= r_nx[5:0];
		end
		mem_rd_q <= digit_mem[rd_idx_q];
	end

endmodule

/* sv/signed_int_to_ascii_radix_unit.sv */
`timescale 1ns / 1ps
// Signed integer to ASCII text converter, top level.
// Depends on s2a_pkg, s2a_front, s2a_queue, s2a_back.
//
// Usage:
//   A request (value, radix, upper_case) is taken on a rising edge with start
//   high and busy low. busy is high while the two-entry request queue is full.
//   Radix values below 2 or above 36 are clamped. The text comes out one
//   character per strobe cycle, most significant digit first, with a leading
//   '-' for negative values; last marks the final character. strobe lasts one
//   cycle and cannot be held off; the block never waits on the receiver.
// Division, with STEPS = ceil(VALUE_BITS/4):
//   The divider produces four quotient bits per cycle; each digit is one
//   full division of the magnitude by the radix in STEPS steps. After
//   division ends, the first character passes through emit_s1 and then the
//   character and strobe registers. Decimal 32-bit values: about 10 digits.
// Reset:
//   arst_n clears the queue and the sequencer; pending requests are dropped.
module signed_int_to_ascii_radix_unit import s2a_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic        [5:0]            radix,
	input  logic                         upper_case,
	output logic        [6:0]            character,
	output logic                         last,
	output logic                         strobe
);

	localparam int QW = $bits(item_cls_t) + VALUE_BITS;

	item_cls_t             f_cls;
	logic [VALUE_BITS-1:0] f_mag;
	logic                  push;
	logic                  pop;
	logic                  q_full;
	logic                  q_empty;
	logic [QW-1:0]         q_rdata;
	item_cls_t             q_cls;
	logic [VALUE_BITS-1:0] q_mag;

	assign q_cls = q_rdata[QW-1:VALUE_BITS];
	assign q_mag = q_rdata[VALUE_BITS-1:0];

	s2a_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.start      (start),
		.value      (value),
		.radix      (radix),
		.upper_case (upper_case),
		.q_full     (q_full),
		.busy       (busy),
		.push       (push),
		.cls        (f_cls),
		.mag        (f_mag)
	);

	s2a_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_cls, f_mag}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	s2a_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cls     (q_cls),
		.q_mag     (q_mag),
		.pop       (pop),
		.character (character),
		.last      (last),
		.strobe    (strobe)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for signed_int_to_ascii_radix_unit: directed table, then random requests.
// Depends on s2a_pkg and the unit; expected text: row text or local radix predictor.
module tb_top import s2a_pkg::*; ();

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} text_char_t;

	typedef struct {
		logic [31:0] value;
		logic [5:0]  radix;
		logic        upper;
		string       text;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] value = '0;
	logic [5:0]  radix = RADIX_MIN;
	logic        upper_case = 1'b0;
	logic [6:0]  character;
	logic        last;
	logic        strobe;

	text_char_t  expected_chars[$];
	stim_row_t   directed_rows[$];
	text_char_t  got_char;
	int          mismatches = 0;
	int          requests_sent = 0;
	int          negatives_sent = 0;
	int          chars_checked = 0;
	bit          idling = 1'b1;

	signed_int_to_ascii_radix_unit #(.VALUE_BITS(32)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.radix     (radix),
		.upper_case(upper_case),
		.character (character),
		.last      (last),
		.strobe    (strobe)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// expected characters for one request, sign first, most significant digit first
	function automatic void predict_text(input logic [31:0] v, input logic [5:0] r,
			input logic up);
		logic [32:0] mag;
		logic [5:0]  base;
		logic [5:0]  d;
		logic [6:0]  digits[$];
		text_char_t  c;
		base = (r < RADIX_MIN) ? RADIX_MIN : ((r > RADIX_MAX) ? RADIX_MAX : r);
		mag = v[31] ? ({1'b0, ~v} + 33'd1) : {1'b0, v};
		do begin
			d = 6'(mag % base);
			if (d >= DIGIT_TEN)
				digits.push_front(7'(d - DIGIT_TEN) + (up ? CH_UPPER : CH_LOWER));
			else
				digits.push_front(7'(d) + CH_ZERO);
			mag = mag / base;
		end while (mag != 0);
		if (v[31]) begin
			c.ch = CH_MINUS;
			c.last = 1'b0;
			expected_chars.push_back(c);
		end
		foreach (digits[i]) begin
			c.ch = digits[i];
			c.last = (i == digits.size() - 1);
			expected_chars.push_back(c);
		end
	endfunction

	task automatic add_row(input logic [31:0] v, input logic [5:0] r, input logic up,
			input string txt);
		stim_row_t row;
		row.value = v;
		row.radix = r;
		row.upper = up;
		row.text = txt;
		directed_rows.push_back(row);
	endtask

	// empty txt means the predictor supplies the expected text
	task automatic send_request(input logic [31:0] v, input logic [5:0] r, input logic up,
			input string txt);
		text_char_t c;
		byte        b;
		while (idling && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		radix <= r;
		upper_case <= up;
		do @(posedge clk); while (busy !== 1'b0);
		if (txt.len() == 0) begin
			predict_text(v, r, up);
		end else begin
			for (int i = 0; i < txt.len(); i++) begin
				b = txt[i];
				c.ch = b[6:0];
				c.last = (i == txt.len() - 1);
				expected_chars.push_back(c);
			end
		end
		requests_sent++;
		if (v[31])
			negatives_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h last=%b",
					character, last));
			end else begin
				got_char = expected_chars.pop_front();
				chars_checked++;
				if (character !== got_char.ch || last !== got_char.last)
					report_mismatch($sformatf("char 0x%02h last=%b, expected 0x%02h last=%b",
						character, last, got_char.ch, got_char.last));
			end
		end
	end

	initial begin
		logic [31:0] v;
		logic [5:0]  r;
		int          drain;

		add_row(32'd0,          6'd10, 1'b0, "0");
		add_row(32'd0,          6'd2,  1'b1, "0");
		add_row(32'd1,          6'd2,  1'b0, "1");
		add_row(32'hFFFF_FFFF,  6'd10, 1'b0, "-1");
		add_row(32'h7FFF_FFFF,  6'd10, 1'b0, "2147483647");
		add_row(32'h8000_0000,  6'd10, 1'b0, "-2147483648");
		add_row(32'h8000_0000,  6'd16, 1'b1, "-80000000");
		add_row(32'h8000_0000,  6'd2,  1'b0, "");
		add_row(32'h7FFF_FFFF,  6'd16, 1'b1, "7FFFFFFF");
		add_row(32'h7FFF_FFFF,  6'd16, 1'b0, "7fffffff");
		add_row(32'd35,         6'd36, 1'b1, "Z");
		add_row(32'd35,         6'd36, 1'b0, "z");
		add_row(-32'sd35,       6'd36, 1'b1, "-Z");
		add_row(32'd10,         6'd0,  1'b0, "1010");
		add_row(32'd10,         6'd1,  1'b0, "1010");
		add_row(32'd35,         6'd63, 1'b0, "z");
		add_row(32'd36,         6'd37, 1'b0, "10");
		add_row(32'd255,        6'd16, 1'b1, "FF");
		add_row(-32'sd255,      6'd8,  1'b0, "-377");
		add_row(32'h7FFF_FFFF,  6'd2,  1'b0, "");
		add_row(32'h7FFF_FFFF,  6'd36, 1'b1, "");
		add_row(32'h8000_0000,  6'd36, 1'b0, "");
		add_row(32'd9,          6'd10, 1'b1, "9");
		add_row(32'd1234567890, 6'd10, 1'b1, "1234567890");
		add_row(-32'sd2147483647, 6'd3, 1'b1, "");

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].value, directed_rows[i].radix,
				directed_rows[i].upper, directed_rows[i].text);

		for (int n = 0; n < 125; n++) begin
			idling = !(n >= 40 && n < 75);
			case ($urandom_range(0, 4))
				0: v = $urandom;
				1: v = $urandom_range(0, 999);
				2: v = 32'd0 - 32'($urandom_range(1, 999));
				3: begin
					v = $urandom >> $urandom_range(0, 31);
					if ($urandom_range(0, 1))
						v = -v;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: v = 32'd0;
						1: v = 32'h7FFF_FFFF;
						2: v = 32'h8000_0000;
						default: v = 32'hFFFF_FFFF;
					endcase
				end
			endcase
			if ($urandom_range(0, 9) == 0)
				r = 6'($urandom_range(0, 63));
			else
				r = 6'($urandom_range(RADIX_MIN, RADIX_MAX));
			send_request(v, r, 1'($urandom_range(0, 1)), "");
		end
		start <= 1'b0;

		drain = 0;
		while (expected_chars.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (64) @(posedge clk);
		if (expected_chars.size() != 0)
			report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));

		$display("Converted %0d requests (%0d negative), %0d characters compared.",
			requests_sent, negatives_sent, chars_checked);
		$display("Radix range 0..63 with clamping, both letter cases, extremes of the value.");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* signed_int_to_ascii_radix_unit.f */
sv/s2a_pkg.sv
sv/s2a_front.sv
sv/s2a_queue.sv
sv/s2a_back.sv
sv/signed_int_to_ascii_radix_unit.sv
tb/tb_top.sv
